@@ rtl/core/psc_pkg.sv @@
// shared types, widths and constants of the pid speed controller
package psc_pkg;

    localparam int DATA_W    = 16;
    localparam int ERR_W     = DATA_W + 1;
    localparam int DERR_W    = DATA_W + 2;
    localparam int INTEG_W   = 40;
    localparam int DERIV_W   = 35;
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = 57;
    localparam int INC_W     = 25;
    localparam int CFG_IDX_W = 3;

    // restoring divide: 17 magnitude bits of the error change, 16 zero fraction bits
    localparam int DIV_STEPS = DERR_W - 1 + DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PD = 3'd5;

    localparam logic [DATA_W-1:0] DRIVE_MAX_RST = 16'd25600;
    localparam logic [DATA_W-1:0] SAMPLE_PD_RST = 16'd6554;

    localparam logic [1:0] LIMB_LO  = 2'd0;
    localparam logic [1:0] LIMB_MID = 2'd1;
    localparam logic [1:0] LIMB_HI  = 2'd2;

    typedef enum logic [1:0] {
        MAC_NOP,
        MAC_CLR,
        MAC_SHR8
    } mac_op_t;

    typedef struct packed {
        mac_op_t                   op;
        logic                      mul_en;
        logic        [OPND_W-1:0]  a;
        logic        [OPND_W-1:0]  b;
        logic        [1:0]         limb;
    } mac_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_INC_MUL,
        ST_INC_DRAIN,
        ST_INC_SHR,
        ST_INT_UPD,
        ST_IP0,
        ST_IP1,
        ST_IP2,
        ST_IP_DRAIN,
        ST_IP_SHR,
        ST_PE,
        ST_DWAIT,
        ST_DP0,
        ST_DP1,
        ST_DP2,
        ST_DP_DRAIN,
        ST_DP_SHR,
        ST_CLAMP
    } state_t;

endpackage

@@ rtl/core/psc_mac.sv @@
// shared 17x17 signed multiplier with limb-shifted accumulator
module psc_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  psc_pkg::mac_ctl_t               ctl,
    output logic signed [psc_pkg::ACC_W-1:0] acc
);
    import psc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic        [1:0]        limb_reg;
    logic                     pend_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  addend;

    assign prod_next = $signed(ctl.a) * $signed(ctl.b);

    // registered product is added to the accumulator in the following cycle at its limb position
    always_comb
    begin
        addend = '0;
        if (pend_reg)
        begin
            addend = $signed({{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg})
                     <<< {limb_reg, 4'b0000};
        end
    end

    always_comb
    begin
        unique case (ctl.op)
            MAC_CLR:  acc_next = '0;
            MAC_SHR8: acc_next = acc_reg >>> 8;
            default:  acc_next = acc_reg + addend;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= ctl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
            limb_reg <= ctl.limb;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

@@ rtl/core/psc_div.sv @@
// restoring divider, one quotient bit per cycle, truncates toward zero
module psc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [psc_pkg::DERR_W-1:0]  dividend,
    input  logic        [psc_pkg::DATA_W-1:0]  divisor,
    output logic                               busy,
    output logic signed [psc_pkg::DERIV_W-1:0] quotient
);
    import psc_pkg::*;

    logic [DIV_STEPS-1:0] q_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DERR_W-2:0]    mag;
    logic [DATA_W:0]      trial;

    // dividend magnitude fits in 17 bits
    assign mag   = dividend[DERR_W-1] ? (DERR_W-1)'(-dividend) : dividend[DERR_W-2:0];
    assign trial = {rem_reg, q_reg[DIV_STEPS-1]} - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= {mag, {DATA_W{1'b0}}};
            rem_reg <= '0;
            neg_reg <= dividend[DERR_W-1];
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[DATA_W])
            begin
                rem_reg <= trial[DATA_W-1:0];
                q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DATA_W-2:0], q_reg[DIV_STEPS-1]};
                q_reg   <= {q_reg[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = neg_reg ? -$signed({{(DERIV_W-DIV_STEPS){1'b0}}, q_reg})
                              :  $signed({{(DERIV_W-DIV_STEPS){1'b0}}, q_reg});

endmodule

@@ rtl/core/pid_speed_controller.sv @@
// top level of the fixed-point pid speed controller with output clamp
//
// usage
//   input channel: measured_speed, target_speed (signed q8.8) and clear,
//   taken when in_valid and in_ready are both high. clear zeroes the
//   integral and the previous error before the word is processed.
//   output channel: drive_out (signed q8.8 percent), one word per input
//   word, held in an output register until out_valid and out_ready meet.
//   config: cfg_we writes cfg_data into register cfg_index (0 gain_p,
//   1 gain_i, 2 gain_d, 3 drive_min, 4 drive_max, 5 sample_period);
//   other indexes are dropped. write only while the block is idle.
// timing
//   a word is accepted in idle and its result is loaded into the output
//   register at the clamp step; in_ready returns the cycle after that. the
//   derivative products wait for the 33-step restoring divider for the
//   derivative; the shared multiplier products for the integral run alongside it.
// reset and stall
//   reset clears the integral, previous error, registers to their defaults
//   and empties the output register. if the receiver stalls, the finished
//   word waits in the output register and the next input word is still
//   accepted; a second result waits in the clamp step until the first leaves.
module pid_speed_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psc_pkg::DATA_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [psc_pkg::DATA_W-1:0] measured_speed,
    input  logic signed [psc_pkg::DATA_W-1:0] target_speed,
    input  logic                             clear,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [psc_pkg::DATA_W-1:0] drive_out
);
    import psc_pkg::*;

    // configuration registers
    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;
    logic signed [DATA_W-1:0] drive_min_reg;
    logic signed [DATA_W-1:0] drive_max_reg;
    logic        [DATA_W-1:0] sample_pd_reg;

    // sequencer and controller state
    state_t                    state_reg;
    state_t                    state_next;
    logic signed [DATA_W-1:0]  meas_reg;
    logic signed [DATA_W-1:0]  targ_reg;
    logic                      clr_reg;
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [ERR_W-1:0]   prev_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_data_reg;

    // datapath signals
    logic signed [ERR_W-1:0]   e_c;
    logic signed [ERR_W-1:0]   prev_eff;
    logic signed [DERR_W-1:0]  de_c;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [DERIV_W-1:0] quot;
    logic signed [DERIV_W-1:0] deriv;
    logic                      div_busy;
    logic                      div_start;
    logic                      out_load;
    mac_ctl_t                  mac_ctl;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   lo_bound;
    logic signed [ACC_W-1:0]   hi_bound;
    logic signed [ACC_W-1:0]   y_lo;
    logic signed [ACC_W-1:0]   y_clamped;
    logic [OPND_W-1:0]         gp_ext;
    logic [OPND_W-1:0]         gi_ext;
    logic [OPND_W-1:0]         gd_ext;

    psc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .acc   (acc)
    );

    psc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (de_c),
        .divisor  (sample_pd_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    // error and its change against the previous word
    assign e_c      = {targ_reg[DATA_W-1], targ_reg} - {meas_reg[DATA_W-1], meas_reg};
    assign prev_eff = clr_reg ? '0 : prev_reg;
    assign de_c     = {e_c[ERR_W-1], e_c} - {prev_eff[ERR_W-1], prev_eff};

    // a zero sample period gives no derivative
    assign deriv = (sample_pd_reg == '0) ? '0 : quot;

    // saturating integral update, increment sits in the low bits of acc
    assign integ_sum = {integ_reg[INTEG_W-1], integ_reg}
                     + {{(INTEG_W+1-INC_W){acc[INC_W-1]}}, acc[INC_W-1:0]};

    always_comb
    begin
        integ_next = integ_sum[INTEG_W-1:0];
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
        begin
            integ_next = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end
    end

    // clamp: lower bound first, then upper bound wins
    assign lo_bound  = ACC_W'(drive_min_reg);
    assign hi_bound  = ACC_W'(drive_max_reg);
    assign y_lo      = (acc < lo_bound) ? lo_bound : acc;
    assign y_clamped = (y_lo > hi_bound) ? hi_bound : y_lo;

    assign gp_ext = {gain_p_reg[DATA_W-1], gain_p_reg};
    assign gi_ext = {gain_i_reg[DATA_W-1], gain_i_reg};
    assign gd_ext = {gain_d_reg[DATA_W-1], gain_d_reg};

    assign out_load = (state_reg == ST_CLAMP) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_ERR;
            ST_ERR:       state_next = ST_INC_MUL;
            ST_INC_MUL:   state_next = ST_INC_DRAIN;
            ST_INC_DRAIN: state_next = ST_INC_SHR;
            ST_INC_SHR:   state_next = ST_INT_UPD;
            ST_INT_UPD:   state_next = ST_IP0;
            ST_IP0:       state_next = ST_IP1;
            ST_IP1:       state_next = ST_IP2;
            ST_IP2:       state_next = ST_IP_DRAIN;
            ST_IP_DRAIN:  state_next = ST_IP_SHR;
            ST_IP_SHR:    state_next = ST_PE;
            ST_PE:        state_next = ST_DWAIT;
            ST_DWAIT:     if (!div_busy) state_next = ST_DP0;
            ST_DP0:       state_next = ST_DP1;
            ST_DP1:       state_next = ST_DP2;
            ST_DP2:       state_next = ST_DP_DRAIN;
            ST_DP_DRAIN:  state_next = ST_DP_SHR;
            ST_DP_SHR:    state_next = ST_CLAMP;
            ST_CLAMP:     if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands, accumulator ops, divider start, in_ready
    always_comb
    begin
        mac_ctl        = '0;
        mac_ctl.op     = MAC_NOP;
        mac_ctl.limb   = LIMB_LO;
        div_start      = 1'b0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_ERR:
            begin
                mac_ctl.op = MAC_CLR;
                div_start  = 1'b1;
            end
            ST_INC_MUL:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.a      = e_reg;
                mac_ctl.b      = {1'b0, sample_pd_reg};
            end
            ST_INC_SHR, ST_IP_SHR, ST_DP_SHR:
            begin
                mac_ctl.op = MAC_SHR8;
            end
            ST_INT_UPD:
            begin
                mac_ctl.op = MAC_CLR;
            end
            ST_IP0:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.a      = gi_ext;
                mac_ctl.b      = {1'b0, integ_reg[15:0]};
            end
            ST_IP1:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.a      = gi_ext;
                mac_ctl.b      = {1'b0, integ_reg[31:16]};
                mac_ctl.limb   = LIMB_MID;
            end
            ST_IP2:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.a      = gi_ext;
                mac_ctl.b      = {{(OPND_W-8){integ_reg[INTEG_W-1]}}, integ_reg[39:32]};
                mac_ctl.limb   = LIMB_HI;
            end
            ST_PE:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.a      = gp_ext;
                mac_ctl.b      = e_reg;
            end
            ST_DP0:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.a      = gd_ext;
                mac_ctl.b      = {1'b0, deriv[15:0]};
            end
            ST_DP1:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.a      = gd_ext;
                mac_ctl.b      = {1'b0, deriv[31:16]};
                mac_ctl.limb   = LIMB_MID;
            end
            ST_DP2:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.a      = gd_ext;
                mac_ctl.b      = {{(OPND_W-3){deriv[DERIV_W-1]}}, deriv[34:32]};
                mac_ctl.limb   = LIMB_HI;
            end
            default:
            begin
                mac_ctl.op = MAC_NOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            drive_min_reg <= '0;
            drive_max_reg <= DRIVE_MAX_RST;
            sample_pd_reg <= SAMPLE_PD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:    gain_p_reg    <= cfg_data;
                REG_GAIN_I:    gain_i_reg    <= cfg_data;
                REG_GAIN_D:    gain_d_reg    <= cfg_data;
                REG_DRIVE_MIN: drive_min_reg <= cfg_data;
                REG_DRIVE_MAX: drive_max_reg <= cfg_data;
                REG_SAMPLE_PD: sample_pd_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // controller state: integral and previous error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else if (state_reg == ST_ERR)
        begin
            prev_reg <= e_c;
            if (clr_reg)
            begin
                integ_reg <= '0;
            end
        end
        else if (state_reg == ST_INT_UPD)
        begin
            integ_reg <= integ_next;
        end
    end

    // input capture and error register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg <= measured_speed;
            targ_reg <= target_speed;
            clr_reg  <= clear;
        end
        if (state_reg == ST_ERR)
        begin
            e_reg <= e_c;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= y_clamped[DATA_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_out = out_data_reg;

endmodule

@@ rtl/core/psc_checker.sv @@
// port-level checks of the pid speed controller and their bind
module psc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [psc_pkg::DATA_W-1:0]    drive_out
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_out))
        else $error("stalled output word changed or dropped");

    // an accepted word keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted word");

    // ready only drops because a word was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input ready dropped without an accepted word");

    // no result shows up the cycle after a word is taken into an empty block
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result word appeared too early");

endmodule

bind pid_speed_controller psc_checker u_psc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive_out (drive_out)
);
